@@ rtl/aes_ctr_pkg.sv @@
package aes_ctr_pkg;

  localparam int unsigned KeyW = 128;
  localparam int unsigned NumRounds = 10;

  typedef enum logic [1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow  = 2'd1,
    RegCtrHigh = 2'd2,
    RegCtrLow  = 2'd3
  } reg_idx_e;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte 0 of the state sits in bits 127:120.
  function automatic logic [KeyW-1:0] sub_shift(input logic [KeyW-1:0] s);
    logic [KeyW-1:0] o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[127-8*(r+4*c) -: 8] = sbox(s[127-8*(r+4*((c+r)%4)) -: 8]);
      end
    end
    return o;
  endfunction

  function automatic logic [KeyW-1:0] mix_columns(input logic [KeyW-1:0] s);
    logic [KeyW-1:0] o;
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      x = a0 ^ a1 ^ a2 ^ a3;
      o[127-32*c -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
      o[119-32*c -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
      o[111-32*c -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      o[103-32*c -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

  function automatic logic [KeyW-1:0] next_round_key(input logic [KeyW-1:0] k,
                                                     input logic [7:0] rc);
    logic [31:0] t;
    logic [KeyW-1:0] o;
    t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    o[127:96] = k[127:96] ^ t;
    o[95:64] = k[95:64] ^ o[127:96];
    o[63:32] = k[63:32] ^ o[95:64];
    o[31:0] = k[31:0] ^ o[63:32];
    return o;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/aes128_ctr_stream_cipher.sv @@
// A word whose byte position is not zero is XORed with the held keystream
// block and registered straight to the output. A word that starts a keystream
// block passes ten AES rounds in the shared round unit, with the round key
// computed alongside, and then the Emit state. The next word waits until the
// result is taken.
// Reset is asynchronous and active low: key and counter clear, position zero.
module aes128_ctr_stream_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_in
  input  logic        s_axis_tuser,  // call_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // data_out
);

  typedef enum logic [1:0] {
    Idle,
    Round,
    Emit
  } state_e;

  state_e state_q;
  logic [127:0] key_q, ctr_q, blk_q, st_q, rk_q;
  logic [3:0] pos_q, rnd_q;
  logic [7:0] din_q;
  logic [127:0] sr, rk_next;
  logic [3:0] pos_use;

  assign sr = aes_ctr_pkg::sub_shift(st_q);
  assign rk_next = aes_ctr_pkg::next_round_key(rk_q, aes_ctr_pkg::rcon(rnd_q));
  assign pos_use = s_axis_tuser ? 4'd0 : pos_q;
  assign s_axis_tready = (state_q == Idle) && !m_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      key_q <= '0;
      ctr_q <= '0;
      pos_q <= '0;
      rnd_q <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          aes_ctr_pkg::RegKeyHigh: key_q[127:64] <= cfg_wdata_i;
          aes_ctr_pkg::RegKeyLow:  key_q[63:0] <= cfg_wdata_i;
          aes_ctr_pkg::RegCtrHigh: ctr_q[127:64] <= cfg_wdata_i;
          aes_ctr_pkg::RegCtrLow:  ctr_q[63:0] <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (state_q)
        Idle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            din_q <= s_axis_tdata;
            pos_q <= pos_use + 4'd1;
            if (pos_use == 4'd0) begin
              st_q <= ctr_q ^ key_q;
              rk_q <= key_q;
              rnd_q <= 4'd1;
              ctr_q <= ctr_q + 128'd1;
              state_q <= Round;
            end else begin
              m_axis_tdata <= s_axis_tdata ^ blk_q[127-8*pos_use -: 8];
              m_axis_tvalid <= 1'b1;
            end
          end
        end
        Round: begin
          rk_q <= rk_next;
          rnd_q <= rnd_q + 4'd1;
          if (rnd_q == 4'(aes_ctr_pkg::NumRounds)) begin
            blk_q <= sr ^ rk_next;
            state_q <= Emit;
          end else begin
            st_q <= aes_ctr_pkg::mix_columns(sr) ^ rk_next;
          end
        end
        Emit: begin
          m_axis_tdata <= din_q ^ blk_q[127:120];
          m_axis_tvalid <= 1'b1;
          state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

endmodule
